// ===== rtl/core/edm_pkg.sv =====
// ----------------------------------------------------------------------------
// edm_pkg
// Shared widths, word types and the pipeline stage record for the
// Euclidean divide/modulo unit.
// ----------------------------------------------------------------------------
package edm_pkg;

  // Working width of the division; port fields are fixed at DATA_W bits.
  localparam int WIDTH  = 64;
  localparam int DATA_W = 64;

  typedef logic [WIDTH-1:0] val_t;

  // Input word
  typedef struct packed {
    logic              mode;      // 0 unsigned, 1 signed Euclidean
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [DATA_W-1:0] quotient;
    logic [DATA_W-1:0] remainder;
    logic              divide_by_zero;
  } out_word_t;

  // State carried down the divider pipeline
  typedef struct packed {
    logic a_neg;   // signed mode and dividend negative
    logic neg_q;   // quotient sign flips
    logic zero;    // divisor is zero
    val_t rem;     // partial remainder
    val_t quo;     // dividend bits still to shift in, quotient bits shifted in
    val_t bm;      // divisor magnitude
  } stage_t;

endpackage

// ===== rtl/core/edm_div_stage.sv =====
// ----------------------------------------------------------------------------
// edm_div_stage
// One registered step of the restoring divider: shift one dividend bit into
// the partial remainder, trial subtract, keep or restore, emit a quotient bit.
// ----------------------------------------------------------------------------
module edm_div_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  edm_pkg::stage_t in_stage,
  output logic            out_valid,
  output edm_pkg::stage_t out_stage
);
  import edm_pkg::*;

  logic [WIDTH:0] sh;
  logic [WIDTH:0] diff;
  stage_t         nxt;

  // Trial subtract of the divisor from the shifted remainder
  always_comb begin
    sh            = {in_stage.rem, in_stage.quo[WIDTH-1]};
    diff          = sh - {1'b0, in_stage.bm};
    nxt           = in_stage;
    nxt.rem       = diff[WIDTH] ? sh[WIDTH-1:0] : diff[WIDTH-1:0];
    nxt.quo       = {in_stage.quo[WIDTH-2:0], ~diff[WIDTH]};
  end

  // Valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (en) begin
      out_stage <= nxt;
    end
  end

endmodule

// ===== rtl/core/euclidean_div_mod.sv =====
// ----------------------------------------------------------------------------
// euclidean_div_mod
// Pipelined WIDTH-bit divider giving quotient and remainder, unsigned or
// signed Euclidean.
// ----------------------------------------------------------------------------
// Accepts one word per cycle while in_ready is high and returns results in
// order, one per word. The operand magnitude stage is loaded at the
// accepting edge, WIDTH stages then each resolve one quotient bit with one
// subtract of a restoring divider, and a final stage applies the Euclidean
// correction and the quotient sign into the output register. A two-entry
// output (register plus skid) keeps taking words while a result waits;
// in_ready drops only when both are full. A zero divisor gives
// divide_by_zero with zero quotient and remainder.
module euclidean_div_mod (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  edm_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output edm_pkg::out_word_t out_word
);
  import edm_pkg::*;

  stage_t         pipe [0:WIDTH];
  logic [WIDTH:0] pipe_v;
  stage_t         head;
  logic           head_valid;
  stage_t         pre;
  val_t           a;
  val_t           b;
  logic           en;
  logic           skid_valid;
  out_word_t      skid_word;
  out_word_t      res;
  stage_t         last;
  logic           adj;
  val_t           q_pos;
  val_t           q_neg;
  val_t           q_fin;
  val_t           r_fin;

  // Pipeline advances unless the skid entry is occupied
  assign en       = ~skid_valid;
  assign in_ready = ~skid_valid;

  // Operand magnitudes and signs
  always_comb begin
    a         = in_word.dividend[WIDTH-1:0];
    b         = in_word.divisor[WIDTH-1:0];
    pre.a_neg = in_word.mode & a[WIDTH-1];
    pre.neg_q = (in_word.mode & a[WIDTH-1]) ^ (in_word.mode & b[WIDTH-1]);
    pre.zero  = (b == '0);
    pre.rem   = '0;
    pre.quo   = pre.a_neg ? val_t'(~a + val_t'(1)) : a;
    pre.bm    = (in_word.mode & b[WIDTH-1]) ? val_t'(~b + val_t'(1)) : b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
    end else if (en) begin
      head_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      head <= pre;
    end
  end

  assign pipe[0]   = head;
  assign pipe_v[0] = head_valid;

  // One quotient bit per stage
  for (genvar k = 0; k < WIDTH; k++) begin : g_step
    edm_div_stage u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (pipe_v[k]),
      .in_stage  (pipe[k]),
      .out_valid (pipe_v[k+1]),
      .out_stage (pipe[k+1])
    );
  end

  // Euclidean correction and quotient sign; -(q+1) is ~q
  always_comb begin
    last  = pipe[WIDTH];
    adj   = last.a_neg & (last.rem != '0);
    q_pos = adj ? val_t'(last.quo + val_t'(1)) : last.quo;
    q_neg = adj ? ~last.quo : val_t'(~last.quo + val_t'(1));
    q_fin = last.neg_q ? q_neg : q_pos;
    r_fin = adj ? val_t'(last.bm - last.rem) : last.rem;
    if (last.zero) begin
      res.quotient       = '0;
      res.remainder      = '0;
      res.divide_by_zero = 1'b1;
    end else begin
      res.quotient       = DATA_W'(q_fin);
      res.remainder      = DATA_W'(r_fin);
      res.divide_by_zero = 1'b0;
    end
  end

  // Output register and skid: control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        skid_valid <= 1'b0;
      end
    end else if (pipe_v[WIDTH]) begin
      if (!out_valid || out_ready) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register and skid: payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_ready) begin
        out_word <= skid_word;
      end
    end else if (pipe_v[WIDTH]) begin
      if (!out_valid || out_ready) begin
        out_word <= res;
      end else begin
        skid_word <= res;
      end
    end
  end

  // Skid is only ever occupied behind a held output word
  a_skid_behind_out : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word without output word");

  // Skid fills only when the output word was held
  a_skid_fill : assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !out_ready))
    else $error("skid filled while output was free");

  // A stalled pipeline keeps its valid bits
  a_stall_hold : assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(pipe_v))
    else $error("pipeline moved during stall");

  // Zero divisor gives zero results
  a_dbz_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.divide_by_zero |->
      (out_word.quotient == '0) && (out_word.remainder == '0))
    else $error("nonzero result on divide by zero");

endmodule
